### src/csv_field_splitter_assert.svh
// Assertion macros shared by the checker of the CSV field splitter.
// Depends on nothing; included by bare file name.
`ifndef CSV_FIELD_SPLITTER_ASSERT_SVH
`define CSV_FIELD_SPLITTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CFS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("csv_field_splitter: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("csv_field_splitter: next-cycle check failed");

`endif

### src/cfs_pkg.sv
`timescale 1ns / 1ps
// Package of the CSV field splitter: word types, command format, codes and helpers.
// Depends on nothing; imported by every module of the block.
package cfs_pkg;

  localparam int SPACE_DEPTH = 32;
  localparam int SPACE_CNT_W = $clog2(SPACE_DEPTH + 1);
  localparam int SPACE_IDX_W = (SPACE_DEPTH > 1) ? $clog2(SPACE_DEPTH) : 1;

  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  localparam logic [7:0] QUOTE_CH = 8'h22;
  localparam logic [7:0] COMMA_CH = 8'h2C;

  localparam logic [1:0] KIND_BYTE      = 2'd0;
  localparam logic [1:0] KIND_FIELD_END = 2'd1;
  localparam logic [1:0] KIND_LINE_END  = 2'd2;

  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_EOL  = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] char_in;
  } cfs_in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_out;
    logic       was_quoted;
    logic       space_overflow;
    logic       last;
  } cfs_out_t;

  typedef enum logic [1:0] {
    OP_EMIT,
    OP_STORE,
    OP_RELEASE,
    OP_END
  } cfs_op_t;

  // One command from the front to the back. count holds the store index for
  // OP_STORE and the number of buffered spaces for OP_RELEASE.
  typedef struct packed {
    cfs_op_t                op;
    logic [7:0]             ch;
    logic [1:0]             kind;
    logic                   quoted;
    logic                   ovf;
    logic [SPACE_CNT_W-1:0] count;
  } cfs_cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DRAIN,
    BK_TAIL
  } cfs_bk_state_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

endpackage

### src/cfs_front.sv
`timescale 1ns / 1ps
// Front part of the CSV field splitter: field state machine that turns each word
// into at most one command for the back part. Depends on cfs_pkg.
module cfs_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_accept,
  input  cfs_pkg::cfs_in_t in_item,
  output logic             cmd_push,
  output cfs_pkg::cfs_cmd_t cmd_data
);
  import cfs_pkg::*;

  logic                   in_quotes_r, in_quotes_nxt;
  logic                   field_quoted_r, field_quoted_nxt;
  logic                   after_close_r, after_close_nxt;
  logic                   quote_pending_r, quote_pending_nxt;
  logic                   seen_text_r, seen_text_nxt;
  logic [SPACE_CNT_W-1:0] space_count_r, space_count_nxt;
  logic                   overflow_r, overflow_nxt;

  always_comb begin
    logic       done;
    logic       emit;
    logic [7:0] c;
    done = 1'b0;
    emit = 1'b0;
    c    = in_item.char_in;

    in_quotes_nxt     = in_quotes_r;
    field_quoted_nxt  = field_quoted_r;
    after_close_nxt   = after_close_r;
    quote_pending_nxt = 1'b0;
    seen_text_nxt     = seen_text_r;
    space_count_nxt   = space_count_r;
    overflow_nxt      = overflow_r;

    cmd_data = '{op: OP_EMIT, ch: c, kind: KIND_BYTE, quoted: 1'b0, ovf: 1'b0,
                 count: '0};

    // Resolve a quote seen inside quotes: doubled quote or closing quote.
    if (quote_pending_r) begin
      if (in_item.mode == MODE_BYTE && c == QUOTE_CH) begin
        emit = 1'b1;
        done = 1'b1;
      end else begin
        in_quotes_nxt   = 1'b0;
        after_close_nxt = 1'b1;
      end
    end

    if (!done) begin
      if (in_item.mode == MODE_EOL || (!in_quotes_nxt && c == COMMA_CH)) begin
        emit = 1'b1;
        cmd_data.op     = OP_END;
        cmd_data.ch     = '0;
        cmd_data.kind   = (in_item.mode == MODE_EOL) ? KIND_LINE_END : KIND_FIELD_END;
        cmd_data.quoted = field_quoted_nxt;
        cmd_data.ovf    = field_quoted_nxt ? 1'b0 : overflow_nxt;
        // Clear all field state.
        in_quotes_nxt     = 1'b0;
        field_quoted_nxt  = 1'b0;
        after_close_nxt   = 1'b0;
        quote_pending_nxt = 1'b0;
        seen_text_nxt     = 1'b0;
        space_count_nxt   = '0;
        overflow_nxt      = 1'b0;
      end else if (in_quotes_nxt) begin
        if (c == QUOTE_CH) quote_pending_nxt = 1'b1;
        else               emit = 1'b1;
      end else if (field_quoted_nxt) begin
        if (c == QUOTE_CH) begin
          emit = 1'b1;
        end else if (!(is_ws(c) && after_close_nxt)) begin
          after_close_nxt = 1'b0;
          emit = 1'b1;
        end
      end else if (c == QUOTE_CH && !seen_text_nxt) begin
        // Opening quote: leading whitespace is already dropped.
        space_count_nxt  = '0;
        field_quoted_nxt = 1'b1;
        in_quotes_nxt    = 1'b1;
        after_close_nxt  = 1'b0;
      end else if (is_ws(c)) begin
        if (seen_text_nxt) begin
          if (space_count_nxt < SPACE_CNT_W'(SPACE_DEPTH)) begin
            emit = 1'b1;
            cmd_data.op    = OP_STORE;
            cmd_data.count = space_count_nxt;
            space_count_nxt = space_count_nxt + 1'b1;
          end else begin
            overflow_nxt = 1'b1;
          end
        end
      end else begin
        emit = 1'b1;
        cmd_data.op    = OP_RELEASE;
        cmd_data.count = space_count_nxt;
        space_count_nxt = '0;
        seen_text_nxt   = 1'b1;
      end
    end

    cmd_push = in_accept && emit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_quotes_r     <= 1'b0;
      field_quoted_r  <= 1'b0;
      after_close_r   <= 1'b0;
      quote_pending_r <= 1'b0;
      seen_text_r     <= 1'b0;
      space_count_r   <= '0;
      overflow_r      <= 1'b0;
    end else if (in_accept) begin
      in_quotes_r     <= in_quotes_nxt;
      field_quoted_r  <= field_quoted_nxt;
      after_close_r   <= after_close_nxt;
      quote_pending_r <= quote_pending_nxt;
      seen_text_r     <= seen_text_nxt;
      space_count_r   <= space_count_nxt;
      overflow_r      <= overflow_nxt;
    end
  end

endmodule

### src/cfs_cmd_fifo.sv
`timescale 1ns / 1ps
// Short command queue between the front and back parts of the CSV field splitter.
// Depends on cfs_pkg.
module cfs_cmd_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  cfs_pkg::cfs_cmd_t push_data,
  output logic              full,
  input  logic              pop,
  output cfs_pkg::cfs_cmd_t pop_data,
  output logic              empty
);
  import cfs_pkg::*;

  cfs_cmd_t              slot_r [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMDQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMDQ_CNT_W-1:0] count_r, count_nxt;

  assign full     = (count_r == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop)      count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_data;
  end

endmodule

### src/cfs_back.sv
`timescale 1ns / 1ps
// Back part of the CSV field splitter: executes commands, owns the whitespace
// buffer and the output register. Depends on cfs_pkg.
module cfs_back (
  input  logic              clk,
  input  logic              rst_n,
  input  cfs_pkg::cfs_cmd_t cmd,
  input  logic              cmd_empty,
  output logic              cmd_pop,
  input  logic              out_take,
  output logic              out_empty,
  output cfs_pkg::cfs_out_t out_item
);
  import cfs_pkg::*;

  cfs_bk_state_t          state_r, state_nxt;
  logic [SPACE_CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [7:0]             rd_data_r;
  logic [7:0]             space_mem [SPACE_DEPTH];
  logic                   mem_we;
  logic                   out_valid_r, out_valid_nxt;
  cfs_out_t               out_item_r, out_item_nxt;
  logic                   out_ld;
  logic                   can_ld;

  assign can_ld    = !out_valid_r || out_take;
  assign out_empty = !out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    state_nxt    = state_r;
    rd_idx_nxt   = rd_idx_r;
    cmd_pop      = 1'b0;
    mem_we       = 1'b0;
    out_ld       = 1'b0;
    out_item_nxt = '{kind: KIND_BYTE, char_out: cmd.ch, was_quoted: 1'b0,
                     space_overflow: 1'b0, last: 1'b1};
    unique case (state_r)
      BK_IDLE: begin
        rd_idx_nxt = '0;
        if (!cmd_empty) begin
          unique case (cmd.op)
            OP_STORE: begin
              mem_we  = 1'b1;
              cmd_pop = 1'b1;
            end
            OP_EMIT: begin
              if (can_ld) begin
                out_ld  = 1'b1;
                cmd_pop = 1'b1;
              end
            end
            OP_END: begin
              out_item_nxt = '{kind: cmd.kind, char_out: 8'h00, was_quoted: cmd.quoted,
                               space_overflow: cmd.ovf, last: 1'b1};
              if (can_ld) begin
                out_ld  = 1'b1;
                cmd_pop = 1'b1;
              end
            end
            OP_RELEASE: begin
              if (cmd.count == '0) begin
                if (can_ld) begin
                  out_ld  = 1'b1;
                  cmd_pop = 1'b1;
                end
              end else begin
                state_nxt = BK_DRAIN;
              end
            end
            default: ;
          endcase
        end
      end
      BK_DRAIN: begin
        // Emit buffered spaces in order; hold the command at the queue head.
        out_item_nxt.char_out = rd_data_r;
        out_item_nxt.last     = 1'b0;
        if (can_ld) begin
          out_ld     = 1'b1;
          rd_idx_nxt = rd_idx_r + 1'b1;
          if (rd_idx_nxt == cmd.count) state_nxt = BK_TAIL;
        end
      end
      BK_TAIL: begin
        if (can_ld) begin
          out_ld    = 1'b1;
          cmd_pop   = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase

    if (out_ld)        out_valid_nxt = 1'b1;
    else if (out_take) out_valid_nxt = 1'b0;
    else               out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_idx_r    <= rd_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) out_item_r <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) space_mem[cmd.count[SPACE_IDX_W-1:0]] <= cmd.ch;
    rd_data_r <= space_mem[rd_idx_nxt[SPACE_IDX_W-1:0]];
  end

endmodule

### src/csv_field_splitter.sv
`timescale 1ns / 1ps
// Top level of the CSV field splitter: front classifier, command queue, back executor.
// Depends on cfs_pkg, cfs_front, cfs_cmd_fifo and cfs_back.
//
// Usage:
//   Input side is a queue write port: drive in_item and raise in_push; the word is
//   taken at a rising edge with in_push high and in_full low. A word is one line
//   byte (mode 0) or an end-of-line marker (mode 1).
//   Result side is a queue read port: while out_empty is low, out_item holds the
//   oldest result; raise out_pop to take it. Results are field bytes, field ends
//   and a line end; last marks the final result caused by an input word.
// Result path: the first result of a word is held in the command queue, then in
//   the output register; a word that releases buffered spaces first waits while
//   the back starts the read of the space buffer.
// Throughput: the front takes one word per cycle while the four-entry command
//   queue has room. The back executes commands in order; a byte that releases
//   buffered interior spaces holds the back while it starts the read of the
//   32-entry space buffer, emits the buffered spaces in order, then the byte.
// Stall: when out_pop stays low, the result holds, the back stops, the queue
//   fills and in_full rises; nothing is lost or repeated.
// Reset: rst_n low at a clock edge clears field state, queue and output register;
//   the space buffer keeps stale data, which is never read before it is written.
module csv_field_splitter (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  cfs_pkg::cfs_in_t  in_item,
  output logic              out_empty,
  input  logic              out_pop,
  output cfs_pkg::cfs_out_t out_item
);
  import cfs_pkg::*;

  logic     in_accept;
  logic     cmd_push;
  cfs_cmd_t cmd_wdata;
  cfs_cmd_t cmd_head;
  logic     cmd_empty;
  logic     cmd_pop;
  logic     out_take;

  // Take a word only when the queue can hold whatever command it makes.
  assign in_accept = in_push && !in_full;
  assign out_take  = out_pop && !out_empty;

  cfs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_item   (in_item),
    .cmd_push  (cmd_push),
    .cmd_data  (cmd_wdata)
  );

  cfs_cmd_fifo u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd_wdata),
    .full      (in_full),
    .pop       (cmd_pop),
    .pop_data  (cmd_head),
    .empty     (cmd_empty)
  );

  cfs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd_head),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .out_take  (out_take),
    .out_empty (out_empty),
    .out_item  (out_item)
  );

endmodule

### src/cfs_checker.sv
`timescale 1ns / 1ps
// Port-level checker of the CSV field splitter, bound to the top level.
// Depends on cfs_pkg and csv_field_splitter_assert.svh.
`include "csv_field_splitter_assert.svh"

module cfs_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_push,
  input logic              in_full,
  input cfs_pkg::cfs_in_t  in_item,
  input logic              out_empty,
  input logic              out_pop,
  input cfs_pkg::cfs_out_t out_item
);
  import cfs_pkg::*;

  logic in_seen;
  assign in_seen = in_push || in_full || in_item.mode;

  `CFS_ASSERT_NEXT(a_out_hold, clk, rst_n, !out_empty && !out_pop, !out_empty && $stable(out_item))
  `CFS_ASSERT_NOW(a_end_is_last, clk, rst_n, !out_empty && out_item.kind != KIND_BYTE, out_item.last && out_item.char_out == 8'h00)
  `CFS_ASSERT_NOW(a_byte_no_flags, clk, rst_n, !out_empty && out_item.kind == KIND_BYTE, !out_item.was_quoted && !out_item.space_overflow)
  `CFS_ASSERT_NOW(a_quoted_no_ovf, clk, rst_n, !out_empty && out_item.was_quoted, !out_item.space_overflow)
  `CFS_ASSERT_NOW(a_kind_legal, clk, rst_n, !out_empty || in_seen, out_empty || out_item.kind == KIND_BYTE || out_item.kind == KIND_FIELD_END || out_item.kind == KIND_LINE_END)

endmodule

bind csv_field_splitter cfs_checker u_cfs_checker (.*);

### sim/tb_csv_field_splitter.sv
`timescale 1ns / 1ps
// Self-checking bench for csv_field_splitter: queued words in, each result checked in order.
// Depends on cfs_pkg for the word types, kind and mode codes, and the space buffer depth.
module tb_csv_field_splitter;
  import cfs_pkg::*;

  localparam int          DRAIN_AT       = 240;   // sender waits here for all results
  localparam int          STALL_AFTER    = 150;   // results seen before the long hold-off
  localparam int          STALL_CYCLES   = 400;
  localparam int          WATCHDOG_LIMIT = 4000;  // cycles with no word taken on either side
  localparam int          TAIL_CYCLES    = 64;
  localparam int          WORD_TARGET    = 480;
  localparam logic [7:0]  SPACE_CH       = 8'h20;
  localparam logic [7:0]  TAB_CH         = 8'h09;
  localparam logic [7:0]  LF_CH          = 8'h0A;
  localparam logic [7:0]  VT_CH          = 8'h0B;
  localparam logic [7:0]  CR_CH          = 8'h0D;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_push = 1'b0;
  logic     in_full;
  cfs_in_t  in_item = '0;
  logic     out_empty;
  logic     out_pop = 1'b0;
  cfs_out_t out_item;

  csv_field_splitter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Words waiting to be offered, and results the splitter still owes.
  cfs_in_t  pending_words[$];
  cfs_out_t expected_results[$];
  int       failures = 0;

  // ---------------------------------------------------------------------------
  // Field splitter prediction: mirrors the tokenizer state one word at a time.
  // ---------------------------------------------------------------------------
  logic       quote_open;      // inside an opening quote
  logic       quote_field;     // field began with an opening quote
  logic       quote_closed;    // closing quote seen, skip whitespace
  logic       quote_waiting;   // quote inside quotes, next word decides
  logic       text_seen;       // unquoted field has had a non-space byte
  logic [7:0] gap_bytes[SPACE_DEPTH];
  int         gap_count;
  logic       gap_dropped;
  int         word_results;

  function automatic logic blank_byte(input logic [7:0] c);
    return (c == SPACE_CH) || ((c >= TAB_CH) && (c <= CR_CH));
  endfunction

  task automatic expect_result(input logic [1:0] kind, input logic [7:0] ch,
                               input logic quoted, input logic ovf);
    cfs_out_t r;
    r.kind           = kind;
    r.char_out       = ch;
    r.was_quoted     = quoted;
    r.space_overflow = ovf;
    r.last           = 1'b0;
    expected_results.insert(expected_results.size(), r);
    word_results++;
  endtask

  // Close the field and drop every piece of field state.
  task automatic expect_field_end(input logic [1:0] kind);
    expect_result(kind, 8'h00, quote_field, quote_field ? 1'b0 : gap_dropped);
    quote_open    = 1'b0;
    quote_field   = 1'b0;
    quote_closed  = 1'b0;
    quote_waiting = 1'b0;
    text_seen     = 1'b0;
    gap_count     = 0;
    gap_dropped   = 1'b0;
  endtask

  task automatic split_word(input cfs_in_t w);
    logic     handled;
    logic     blank;
    cfs_out_t tail;
    handled      = 1'b0;
    blank        = blank_byte(w.char_in);
    word_results = 0;
    // A waiting quote is either half of a doubled quote or the closing quote.
    if (quote_waiting) begin
      quote_waiting = 1'b0;
      if (w.mode == MODE_BYTE && w.char_in == QUOTE_CH) begin
        expect_result(KIND_BYTE, QUOTE_CH, 1'b0, 1'b0);
        handled = 1'b1;
      end else begin
        quote_open   = 1'b0;
        quote_closed = 1'b1;
      end
    end
    if (!handled) begin
      if (w.mode == MODE_EOL) begin
        expect_field_end(KIND_LINE_END);
      end else if (quote_open) begin
        if (w.char_in == QUOTE_CH) quote_waiting = 1'b1;
        else expect_result(KIND_BYTE, w.char_in, 1'b0, 1'b0);
      end else if (w.char_in == COMMA_CH) begin
        expect_field_end(KIND_FIELD_END);
      end else if (quote_field) begin
        // After the closing quote: skip blanks until some other non-quote byte.
        if (w.char_in == QUOTE_CH) begin
          expect_result(KIND_BYTE, w.char_in, 1'b0, 1'b0);
        end else if (!(blank && quote_closed)) begin
          quote_closed = 1'b0;
          expect_result(KIND_BYTE, w.char_in, 1'b0, 1'b0);
        end
      end else if (w.char_in == QUOTE_CH && !text_seen) begin
        gap_count    = 0;
        quote_field  = 1'b1;
        quote_open   = 1'b1;
        quote_closed = 1'b0;
      end else if (blank) begin
        // Hold interior blanks; drop leading ones and any beyond the buffer.
        if (text_seen) begin
          if (gap_count < SPACE_DEPTH) begin
            gap_bytes[gap_count] = w.char_in;
            gap_count++;
          end else begin
            gap_dropped = 1'b1;
          end
        end
      end else begin
        for (int i = 0; i < gap_count; i++) expect_result(KIND_BYTE, gap_bytes[i], 1'b0, 1'b0);
        gap_count = 0;
        expect_result(KIND_BYTE, w.char_in, 1'b0, 1'b0);
        text_seen = 1'b1;
      end
    end
    if (word_results > 0) begin
      tail      = expected_results.pop_back();
      tail.last = 1'b1;
      expected_results.insert(expected_results.size(), tail);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus building.
  // ---------------------------------------------------------------------------
  task automatic add_byte(input logic [7:0] c);
    cfs_in_t w;
    w.mode    = MODE_BYTE;
    w.char_in = c;
    pending_words.insert(pending_words.size(), w);
  endtask

  task automatic add_eol(input logic [7:0] c);
    cfs_in_t w;
    w.mode    = MODE_EOL;
    w.char_in = c;
    pending_words.insert(pending_words.size(), w);
  endtask

  function automatic logic [7:0] rand_blank();
    int k;
    k = $urandom_range(0, 5);
    return (k == 5) ? SPACE_CH : TAB_CH + 8'(k);
  endfunction

  function automatic logic [7:0] rand_text();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (blank_byte(c) || c == COMMA_CH || c == QUOTE_CH) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  // Build one line of mostly well-formed fields with random content.
  task automatic gen_line();
    int nf;
    int sort;
    int n;
    nf = $urandom_range(1, 5);
    for (int f = 0; f < nf; f++) begin
      if (f > 0) add_byte(COMMA_CH);
      sort = $urandom_range(0, 9);
      if (sort <= 4) begin
        // Unquoted: blanks around and between tokens, now and then a run past the buffer.
        repeat ($urandom_range(0, 2)) add_byte(rand_blank());
        for (int t = $urandom_range(1, 4); t > 0; t--) begin
          n = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 36) : $urandom_range(0, 3);
          repeat (n) add_byte(rand_blank());
          repeat ($urandom_range(1, 4))
            add_byte(($urandom_range(0, 11) == 0) ? QUOTE_CH : rand_text());
        end
        repeat ($urandom_range(0, 2)) add_byte(rand_blank());
      end else if (sort <= 7) begin
        // Quoted: raw content with doubled quotes and commas, sometimes left open.
        repeat ($urandom_range(0, 2)) add_byte(rand_blank());
        add_byte(QUOTE_CH);
        repeat ($urandom_range(0, 6)) begin
          case ($urandom_range(0, 7))
            0: begin
              add_byte(QUOTE_CH);
              add_byte(QUOTE_CH);
            end
            1: add_byte(COMMA_CH);
            2: add_byte(rand_blank());
            default: add_byte(8'($urandom_range(0, 255)));
          endcase
        end
        if ($urandom_range(0, 7) != 0) add_byte(QUOTE_CH);
        case ($urandom_range(0, 3))
          1: repeat ($urandom_range(1, 3)) add_byte(rand_blank());
          2: begin
            add_byte(rand_blank());
            add_byte(QUOTE_CH);
            add_byte(rand_blank());
          end
          3: begin
            add_byte(rand_blank());
            add_byte(rand_text());
          end
          default: ;
        endcase
      end else if (sort == 8) begin
        repeat ($urandom_range(1, 5)) add_byte(8'($urandom_range(0, 255)));
      end
    end
    add_eol(8'($urandom_range(0, 255)));
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer queued words in bursts; hold a word while the splitter is full.
  // ---------------------------------------------------------------------------
  int      words_sent = 0;
  int      burst_left = 0;
  int      gap_left = 0;
  logic    drained = 1'b0;
  logic    offer;
  cfs_in_t next_word;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        split_word(in_item);
        words_sent++;
      end
      // Keep push high and the word stable until it is taken.
      if (!(in_push && in_full)) begin
        offer     = 1'b0;
        next_word = '0;
        // Pause once until every owed result has come out.
        if (!drained && words_sent >= DRAIN_AT && expected_results.size() == 0) drained = 1'b1;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_words.size() > 0 && (drained || words_sent < DRAIN_AT)) begin
          offer     = 1'b1;
          next_word = pending_words.pop_front();
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 50);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end
        in_push <= offer;
        if (offer) in_item <= next_word;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each taken result against the oldest expectation.
  // ---------------------------------------------------------------------------
  int       results_seen = 0;
  int       stall_left = 0;
  logic     stall_done = 1'b0;
  int       seg_left = 0;
  int       seg_rate = 0;
  logic     pop_next;
  cfs_out_t want;

  task automatic report_field(input string name, input logic [7:0] exp_v,
                              input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t: result with none expected, expected nothing, actual %0h",
                   $time, out_item);
          failures++;
        end else begin
          want = expected_results.pop_front();
          report_field("kind", 8'(want.kind), 8'(out_item.kind));
          report_field("char_out", want.char_out, out_item.char_out);
          report_field("was_quoted", 8'(want.was_quoted), 8'(out_item.was_quoted));
          report_field("space_overflow", 8'(want.space_overflow), 8'(out_item.space_overflow));
          report_field("last", 8'(want.last), 8'(out_item.last));
        end
      end
      // Hold off once for a long stretch so the splitter backs up into in_full.
      if (!stall_done && results_seen >= STALL_AFTER) begin
        stall_left = STALL_CYCLES;
        stall_done = 1'b1;
      end
      if (stall_left > 0) begin
        stall_left--;
        pop_next = 1'b0;
      end else begin
        // Advance through segments of steady, half, quarter and no popping.
        if (seg_left == 0) begin
          seg_left = $urandom_range(1, 60);
          seg_rate = $urandom_range(0, 3);
        end
        seg_left--;
        case (seg_rate)
          0: pop_next = 1'b1;
          1: pop_next = 1'($urandom_range(0, 1));
          2: pop_next = ($urandom_range(0, 3) == 0);
          default: pop_next = 1'b0;
        endcase
      end
      out_pop <= pop_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run when neither side takes a word for too long.
  // ---------------------------------------------------------------------------
  int idle_cycles = 0;

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("csv_field_splitter verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence: build the stimulus, release reset, wait for the last result.
  // ---------------------------------------------------------------------------
  initial begin
    quote_open    = 1'b0;
    quote_field   = 1'b0;
    quote_closed  = 1'b0;
    quote_waiting = 1'b0;
    text_seen     = 1'b0;
    gap_count     = 0;
    gap_dropped   = 1'b0;

    // Leading blanks before a quote, raw extremes and a doubled quote inside.
    add_byte(SPACE_CH);
    add_byte(TAB_CH);
    add_byte(QUOTE_CH);
    add_byte(8'h00);
    add_byte(COMMA_CH);
    add_byte(QUOTE_CH);
    add_byte(QUOTE_CH);
    add_byte(8'hFF);
    // Close, skip blanks, literal quote that keeps skipping, then a byte ends it.
    add_byte(QUOTE_CH);
    add_byte(CR_CH);
    add_byte(QUOTE_CH);
    add_byte(VT_CH);
    add_byte("z");
    add_byte(COMMA_CH);
    // Unquoted: interior blanks released by a literal quote, trailing blank trimmed.
    add_byte("a");
    add_byte(LF_CH);
    add_byte(8'h0C);
    add_byte(QUOTE_CH);
    add_byte(SPACE_CH);
    add_byte(COMMA_CH);
    // Waiting quote closed by a comma, unterminated quote at end of line.
    add_byte(QUOTE_CH);
    add_byte("k");
    add_byte(QUOTE_CH);
    add_byte(COMMA_CH);
    add_byte(QUOTE_CH);
    add_byte("u");
    add_eol(8'hA5);
    // Empty quoted field with its quote still waiting at end of line.
    add_byte(QUOTE_CH);
    add_byte(QUOTE_CH);
    add_eol(QUOTE_CH);

    while (pending_words.size() < WORD_TARGET) gen_line();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() != 0 || in_push) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (failures == 0) begin
      $display("csv_field_splitter verification clean");
    end else begin
      $display("csv_field_splitter verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/cfs_pkg.sv
src/cfs_front.sv
src/cfs_cmd_fifo.sv
src/cfs_back.sv
src/csv_field_splitter.sv
src/cfs_checker.sv
sim/tb_csv_field_splitter.sv
